@@ design/pkrg_pkg.sv @@
// Package for the per-key timestamp replay guard.
// Holds sizes, payload and record structs, control codes and the FSM state type.
// No dependencies; every other design file refers to it by scoped names.
package pkrg_pkg;

  localparam int CAPACITY = 64;                    // record cells in the chain
  localparam int KEY_BITS = 16;                    // key id width
  localparam int CAP_W    = $clog2(CAPACITY);      // cell index width
  localparam int CNT_W    = $clog2(CAPACITY + 1);  // record count, 0..CAPACITY
  localparam int STAMP_W  = 63;
  localparam int MONO_W   = 48;
  localparam int DROP_W   = 7;
  localparam int CFG_W    = 32;
  localparam int MAXR_W   = 6;
  localparam int ADDR_W   = 4;

  typedef logic [CAP_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DROP_W-1:0] drop_t;
  typedef logic [MONO_W:0]   mono_ext_t;
  typedef logic [STAMP_W:0]  stamp_ext_t;
  typedef logic [CFG_W-1:0]  word_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_GRACE   = 2'd1,
    ST_REORDER = 2'd2,
    ST_INNER   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_GRACE    = 2'd0,
    REG_LIFETIME = 2'd1,
    REG_MAX_REC  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLEAN,
    S_DECIDE
  } state_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key_id;
    logic [STAMP_W-1:0]  command_stamp;
    logic [STAMP_W-1:0]  wall_now_ms;
    logic [MONO_W-1:0]   mono_now_ms;
    logic                inner_ok;
  } in_req_t;

  typedef struct packed {
    logic              accepted;
    logic [1:0]        status;
    logic [DROP_W-1:0] records_dropped;
  } out_res_t;

  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] key;
    logic [STAMP_W-1:0]  stamp;
    logic [MONO_W-1:0]   refreshed;
  } rec_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic shift_all;   // every cell takes its upper neighbor
    logic shift_seen;  // cells at or above the matching cell take their upper neighbor
    logic load;        // cell at wr_idx loads the new record
    idx_t wr_idx;
  } cell_cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0]  grace_period_ms;
    logic [CFG_W-1:0]  record_lifetime_ms;
    logic [MAXR_W-1:0] max_records;
  } cfg_t;

endpackage

@@ design/pkrg_cell.sv @@
// One record cell of the replay guard chain.
// Holds one record, shifts toward the oldest end, and flags a key match.
// Depends on pkrg_pkg.
module pkrg_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pkrg_pkg::idx_t       idx,
  input  pkrg_pkg::cell_cmd_t  cmd,
  input  pkrg_pkg::in_req_t    req,
  input  pkrg_pkg::rec_t       rec_next,
  input  logic                 seen_in,
  input  logic                 older_in,
  output pkrg_pkg::rec_t       rec_out,
  output logic                 seen_out,
  output logic                 older_out
);

  logic                          valid_r, valid_nxt;
  logic [pkrg_pkg::KEY_BITS-1:0] key_r, key_nxt;
  logic [pkrg_pkg::STAMP_W-1:0]  stamp_r, stamp_nxt;
  logic [pkrg_pkg::MONO_W-1:0]   refr_r, refr_nxt;
  logic                          match_r, match_nxt;
  logic                          older_r, older_nxt;
  logic                          take, load;

  assign seen_out  = seen_in | match_r;
  assign older_out = older_in | older_r;
  assign take      = cmd.shift_all | (cmd.shift_seen & seen_out);
  assign load      = cmd.load & (idx == cmd.wr_idx);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    stamp_nxt = stamp_r;
    refr_nxt  = refr_r;
    if (load) begin
      valid_nxt = 1'b1;
      key_nxt   = req.key_id;
      stamp_nxt = req.command_stamp;
      refr_nxt  = req.mono_now_ms;
    end else if (take) begin
      valid_nxt = rec_next.valid;
      key_nxt   = rec_next.key;
      stamp_nxt = rec_next.stamp;
      refr_nxt  = rec_next.refreshed;
    end
    // keys are unique in the table, so at most one cell matches
    match_nxt = valid_r & (key_r == req.key_id);
    older_nxt = match_nxt & (req.command_stamp <= stamp_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
      older_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
      older_r <= older_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    stamp_r <= stamp_nxt;
    refr_r  <= refr_nxt;
  end

  assign rec_out = '{valid: valid_r, key: key_r, stamp: stamp_r, refreshed: refr_r};

endmodule

@@ design/pkrg_regs.sv @@
// Configuration registers of the replay guard behind an APB-style port.
// Grace period, record lifetime and record limit. Depends on pkrg_pkg.
module pkrg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pkrg_pkg::ADDR_W-1:0] paddr,
  input  logic [pkrg_pkg::CFG_W-1:0]  pwdata,
  output logic [pkrg_pkg::CFG_W-1:0]  prdata,
  output logic                        pready,
  output pkrg_pkg::cfg_t              cfg
);

  pkrg_pkg::cfg_t cfg_r, cfg_nxt;
  logic           wr_en;
  logic [1:0]     reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];  // byte lanes ignored

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        pkrg_pkg::REG_GRACE:    cfg_nxt.grace_period_ms    = pwdata;
        pkrg_pkg::REG_LIFETIME: cfg_nxt.record_lifetime_ms = pwdata;
        pkrg_pkg::REG_MAX_REC:  cfg_nxt.max_records        = pwdata[pkrg_pkg::MAXR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      pkrg_pkg::REG_GRACE:    prdata = cfg_r.grace_period_ms;
      pkrg_pkg::REG_LIFETIME: prdata = cfg_r.record_lifetime_ms;
      pkrg_pkg::REG_MAX_REC:  prdata = pkrg_pkg::word_t'(cfg_r.max_records);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grace_period_ms    <= 32'd120000;
      cfg_r.record_lifetime_ms <= 32'd3600000;
      cfg_r.max_records        <= 6'd63;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ design/pkrg_ctrl.sv @@
// Sequencer of the replay guard: request capture, cleanup, decision, result.
// Drives the command broadcast to the cell chain. Depends on pkrg_pkg.
module pkrg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  pkrg_pkg::in_req_t    in_data,
  input  pkrg_pkg::cfg_t       cfg,
  input  pkrg_pkg::rec_t       oldest,
  input  logic                 found,
  input  logic                 older,
  output logic                 busy,
  output pkrg_pkg::in_req_t    req,
  output pkrg_pkg::cell_cmd_t  cmd,
  output logic                 out_valid,
  output pkrg_pkg::out_res_t   out_data
);

  pkrg_pkg::state_t   state_r, state_nxt;
  pkrg_pkg::in_req_t  req_r, req_nxt;
  pkrg_pkg::cnt_t     count_r, count_nxt;
  pkrg_pkg::cnt_t     dropped_r, dropped_nxt;
  pkrg_pkg::cnt_t     wr_pos;
  logic               grace_bad_r, grace_bad_nxt;
  logic               out_valid_r, out_valid_nxt;
  pkrg_pkg::out_res_t res_r, res_nxt;
  pkrg_pkg::status_t  status;
  pkrg_pkg::mono_ext_t  exp_at;
  pkrg_pkg::stamp_ext_t st_hi, wall_hi;
  logic               expired, over_limit, do_drop, full, ins, take_req;

  assign exp_at     = {1'b0, oldest.refreshed} +
                      pkrg_pkg::mono_ext_t'(cfg.record_lifetime_ms);
  assign expired    = exp_at <= {1'b0, req_r.mono_now_ms};
  assign over_limit = count_r > pkrg_pkg::cnt_t'(cfg.max_records);
  assign st_hi      = {1'b0, req_r.command_stamp} +
                      pkrg_pkg::stamp_ext_t'(cfg.grace_period_ms);
  assign wall_hi    = {1'b0, req_r.wall_now_ms} +
                      pkrg_pkg::stamp_ext_t'(cfg.grace_period_ms);
  assign full       = count_r == pkrg_pkg::cnt_t'(pkrg_pkg::CAPACITY);
  assign busy       = state_r == pkrg_pkg::S_CLEAN;
  assign take_req   = start & ~busy;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    do_drop       = 1'b0;
    ins           = 1'b0;
    status        = pkrg_pkg::ST_OK;
    wr_pos        = count_r;
    cmd           = '0;
    grace_bad_nxt = (st_hi < {1'b0, req_r.wall_now_ms}) |
                    ({1'b0, req_r.command_stamp} > wall_hi);

    case (state_r)
      pkrg_pkg::S_IDLE: ;
      pkrg_pkg::S_CLEAN: begin
        do_drop = (count_r != '0) & (expired | over_limit);
        if (do_drop) begin
          cmd.shift_all = 1'b1;
          count_nxt     = count_r - 1'b1;
          dropped_nxt   = dropped_r + 1'b1;
        end else begin
          // cell flags sampled this cycle see the final table
          state_nxt = pkrg_pkg::S_DECIDE;
        end
      end
      pkrg_pkg::S_DECIDE: begin
        if (grace_bad_r)
          status = pkrg_pkg::ST_GRACE;
        else if (found & older)
          status = pkrg_pkg::ST_REORDER;
        else if (!req_r.inner_ok)
          status = pkrg_pkg::ST_INNER;
        ins = status == pkrg_pkg::ST_OK;
        if (found | full)
          wr_pos = count_r - 1'b1;
        cmd.load       = ins;
        cmd.shift_seen = ins & found;
        cmd.shift_all  = ins & full & ~found;
        cmd.wr_idx     = wr_pos[pkrg_pkg::CAP_W-1:0];
        if (ins & ~found & ~full)
          count_nxt = count_r + 1'b1;
        out_valid_nxt           = 1'b1;
        res_nxt.accepted        = ins;
        res_nxt.status          = status;
        res_nxt.records_dropped = pkrg_pkg::drop_t'(dropped_r);
        state_nxt               = pkrg_pkg::S_IDLE;
      end
      default: state_nxt = pkrg_pkg::S_IDLE;
    endcase

    // a new request may enter while the previous one is deciding
    if (take_req) begin
      req_nxt     = in_data;
      dropped_nxt = '0;
      state_nxt   = pkrg_pkg::S_CLEAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pkrg_pkg::S_IDLE;
      count_r     <= '0;
      dropped_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    res_r       <= res_nxt;
    grace_bad_r <= grace_bad_nxt;
  end

  assign req       = req_r;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

endmodule

@@ design/per_key_timestamp_replay_guard.sv @@
// Per-key timestamp replay guard: top level.
// Depends on pkrg_pkg, pkrg_cell, pkrg_regs and pkrg_ctrl.
//
//   A request (in_data: key id, command stamp, wall and monotonic time,
//   inner check flag) is taken at a clock edge with start high and busy low.
//   One result (out_data: accepted, status, records dropped) follows on
//   out_valid, high for exactly one cycle; the receiver cannot stall it.
//   The record table is a chain of CAPACITY cells, oldest record in cell 0.
//   Cleanup drops one record per cycle by shifting the chain toward cell 0
//   while cell 0 is expired or the count is over max_records. The first
//   cycle without a drop samples key match and stamp order in every cell;
//   the next cycle decides and, on acceptance, moves the record to the top.
//   A request stays in cleanup (busy high) through its drops and the sampling
//   cycle, then moves to the decision state; out_valid is registered from the
//   decision state. busy is low in the decision cycle, so a new request can
//   be taken while the previous one decides.
//   Reset (rst_n low, synchronous) empties the table and loads the register
//   defaults. Registers (grace 0x0, lifetime 0x4, record limit 0x8) must be
//   written over the APB-style port while idle; this is not enforced.
module per_key_timestamp_replay_guard (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        start,
  output logic                        busy,
  input  pkrg_pkg::in_req_t           in_data,
  // result channel
  output logic                        out_valid,
  output pkrg_pkg::out_res_t          out_data,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pkrg_pkg::ADDR_W-1:0] paddr,
  input  logic [pkrg_pkg::CFG_W-1:0]  pwdata,
  output logic [pkrg_pkg::CFG_W-1:0]  prdata,
  output logic                        pready
);

  pkrg_pkg::cfg_t      cfg;
  pkrg_pkg::in_req_t   req;
  pkrg_pkg::cell_cmd_t cmd;

  // rec_w[i] is cell i's record; the slot past the top reads as empty
  pkrg_pkg::rec_t rec_w [pkrg_pkg::CAPACITY+1];
  // match and stamp-order flags accumulate along the chain
  logic seen_w  [pkrg_pkg::CAPACITY+1];
  logic older_w [pkrg_pkg::CAPACITY+1];

  assign rec_w[pkrg_pkg::CAPACITY] = '0;
  assign seen_w[0]                 = 1'b0;
  assign older_w[0]                = 1'b0;

  pkrg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  for (genvar i = 0; i < pkrg_pkg::CAPACITY; i++) begin : g_cell
    pkrg_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (pkrg_pkg::idx_t'(i)),
      .cmd       (cmd),
      .req       (req),
      .rec_next  (rec_w[i+1]),
      .seen_in   (seen_w[i]),
      .older_in  (older_w[i]),
      .rec_out   (rec_w[i]),
      .seen_out  (seen_w[i+1]),
      .older_out (older_w[i+1])
    );
  end

  pkrg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .cfg       (cfg),
    .oldest    (rec_w[0]),
    .found     (seen_w[pkrg_pkg::CAPACITY]),
    .older     (older_w[pkrg_pkg::CAPACITY]),
    .busy      (busy),
    .req       (req),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ design/pkrg_checker.sv @@
// Port-level checks for the replay guard, bound to the top level.
// Depends on pkrg_pkg and per_key_timestamp_replay_guard.
module pkrg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input pkrg_pkg::out_res_t out_data
);

  // a taken request always enters cleanup
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after request");

  // no result directly follows another
  a_no_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in a row");

  // a result follows a cleanup phase
  a_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy, 2))
    else $error("result without request");

  a_acc_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.accepted == (out_data.status == pkrg_pkg::ST_OK)))
    else $error("accepted flag disagrees with status");

  a_drop_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.records_dropped <= pkrg_pkg::drop_t'(pkrg_pkg::CAPACITY)))
    else $error("drop count out of range");

endmodule

bind per_key_timestamp_replay_guard pkrg_checker u_pkrg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
